FILE: design/sle_pkg.sv
package sle_pkg;

    localparam int OPCODE_BITS   = 3;
    localparam int POSITION_BITS = 7;
    localparam int VALUE_BITS    = 32;
    localparam int STATUS_BITS   = 2;

    localparam logic [OPCODE_BITS-1:0] OP_INSERT = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_DELETE = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_GET    = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_LOCATE = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [VALUE_BITS-1:0]    element;
        logic [POSITION_BITS-1:0] found_position;
        logic [POSITION_BITS-1:0] list_length;
    } t_result;

endpackage

FILE: design/sle_mem.sv
module sle_mem
    import sle_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sle_ctrl.sv
module sle_ctrl
    import sle_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32,
    parameter int AW           = 6,
    parameter int CW           = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPCODE_BITS-1:0]   i_opcode,
    input  logic [POSITION_BITS-1:0] i_position,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [ELEMENT_BITS-1:0]  i_rd_data,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [ELEMENT_BITS-1:0]  o_wr_data
);

    localparam int CMPW = ((CW > POSITION_BITS) ? CW : POSITION_BITS) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [OPCODE_BITS-1:0]   r_op, n_op;
    logic [AW-1:0]            r_pos_m1, n_pos_m1;
    logic [ELEMENT_BITS-1:0]  r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_end, n_end;
    logic                     r_pv, n_pv;
    logic [AW-1:0]            r_pa, n_pa;
    logic [STATUS_BITS-1:0]   r_status, n_status;
    logic [VALUE_BITS-1:0]    r_elem, n_elem;
    logic [POSITION_BITS-1:0] r_found, n_found;

    logic [ELEMENT_BITS-1:0]  w_in_val;
    logic [VALUE_BITS-1:0]    w_wide;
    logic [CMPW-1:0]          w_p;
    logic [CMPW-1:0]          w_c;
    logic [AW-1:0]            w_pm1;
    logic [AW-1:0]            w_cm1;
    logic                     w_accept;
    logic                     w_match;

    if (ELEMENT_BITS > VALUE_BITS) begin : g_val_wide
        assign w_in_val = {{(ELEMENT_BITS - VALUE_BITS){1'b0}}, i_value};
    end else begin : g_val_narrow
        assign w_in_val = i_value[ELEMENT_BITS-1:0];
    end

    if (ELEMENT_BITS >= VALUE_BITS) begin : g_out_wide
        assign w_wide = i_rd_data[VALUE_BITS-1:0];
    end else begin : g_out_narrow
        assign w_wide = {{(VALUE_BITS - ELEMENT_BITS){i_rd_data[ELEMENT_BITS-1]}}, i_rd_data};
    end

    assign w_p      = CMPW'(i_position);
    assign w_c      = CMPW'(r_count);
    assign w_pm1    = AW'(w_p - CMPW'(1));
    assign w_cm1    = AW'(w_c - CMPW'(1));
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_match  = r_pv && (r_op == OP_LOCATE) && (i_rd_data == r_val);

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, element: r_elem, found_position: r_found,
                           list_length: POSITION_BITS'(r_count)};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_op      = r_op;
        n_pos_m1  = r_pos_m1;
        n_val     = r_val;
        n_idx     = r_idx;
        n_end     = r_end;
        n_pv      = 1'b0;
        n_pa      = r_pa;
        n_status  = r_status;
        n_elem    = r_elem;
        n_found   = r_found;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pa;
        o_wr_data = i_rd_data;

        if (r_pv) begin
            case (r_op)
                OP_INSERT: begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pa + AW'(1);
                end
                OP_DELETE: begin
                    if (r_pa == r_pos_m1) begin
                        n_elem = w_wide;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_pa - AW'(1);
                    end
                end
                OP_GET: begin
                    n_elem = w_wide;
                end
                default: begin
                    if (w_match) begin
                        n_status = ST_OK;
                        n_found  = POSITION_BITS'(r_pa) + POSITION_BITS'(1);
                    end
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_opcode;
                    n_val    = w_in_val;
                    n_pos_m1 = w_pm1;
                    n_status = ST_OK;
                    n_elem   = '0;
                    n_found  = '0;
                    n_state  = S_DONE;
                    case (i_opcode)
                        OP_INSERT: begin
                            if (w_p < CMPW'(1) || w_p > w_c + CMPW'(1)) begin
                                n_status = ST_BADPOS;
                            end else if (w_c >= CMPW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                if (w_p == w_c + CMPW'(1)) begin
                                    n_state = S_PUT;
                                end else begin
                                    n_idx   = w_cm1;
                                    n_end   = w_pm1;
                                    n_state = S_RUN;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (w_p < CMPW'(1) || w_p > w_c) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_idx   = w_pm1;
                                n_end   = w_cm1;
                                n_state = S_RUN;
                            end
                        end
                        OP_GET: begin
                            if (w_p < CMPW'(1) || w_p > w_c) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_idx   = w_pm1;
                                n_end   = w_pm1;
                                n_state = S_RUN;
                            end
                        end
                        OP_LOCATE: begin
                            n_status = ST_NOTFOUND;
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_end   = w_cm1;
                                n_state = S_RUN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (w_match) begin
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_pv    = 1'b1;
                    n_pa    = r_idx;
                    if (r_idx == r_end) begin
                        n_state = S_DRAIN;
                    end else if (r_op == OP_INSERT) begin
                        n_idx = r_idx - AW'(1);
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_DRAIN: begin
                n_state = (r_op == OP_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos_m1;
                o_wr_data = r_val;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
        end
        r_op     <= n_op;
        r_pos_m1 <= n_pos_m1;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_pa     <= n_pa;
        r_status <= n_status;
        r_elem   <= n_elem;
        r_found  <= n_found;
    end

endmodule

FILE: design/sequential_list_engine_core.sv
// Ordered list of up to CAPACITY signed elements held in a single-port-read RAM and
// walked by one address counter and comparator. A word on s_axis carries an opcode
// (insert, delete, get, locate, clear); exactly one result word per request comes out
// on m_axis. The slave side is ready only while no request is in progress. Clear, errors
// and an append insert skip the walk; insert and delete shift the entries from the
// position to the tail, get reads one entry, and locate scans from the head and stops on
// a hit. The RAM moves or compares one entry per cycle. A finished result waits in the
// output register until taken.
module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[6:0], value[38:7], zero pad
    input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // element[31:0], found_position[38:32],
                                       // list_length[45:39], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic [ELEMENT_BITS-1:0] w_rd_data;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [ELEMENT_BITS-1:0] w_wr_data;
    logic                    w_res_valid;
    logic                    w_take;
    t_result                 w_res;

    logic                    r_ov;
    t_result                 r_out;

    sle_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    sle_ctrl #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_position  (s_axis_tdata[6:0]),
        .i_value     (s_axis_tdata[38:7]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_take),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    assign w_take = w_res_valid && (!r_ov || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_out.list_length, r_out.found_position, r_out.element};
    assign m_axis_tuser  = r_out.status;

endmodule

FILE: tb/tb_sequential_list_engine_core.sv
`timescale 1ns / 100ps

module tb_sequential_list_engine_core;
    import sle_pkg::*;

    localparam int LIST_CAPACITY = 64;
    localparam int TOTAL_REQUESTS = 1600;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [OPCODE_BITS-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [OPCODE_BITS-1:0] OP_MID_UNUSED   = 3'd6;
    localparam logic [OPCODE_BITS-1:0] OP_LAST_CODE    = 3'd7;

    localparam int MODE_FILL   = 0;
    localparam int MODE_DRAIN  = 1;
    localparam int MODE_MIXED  = 2;
    localparam int MODE_LOOKUP = 3;

    class list_scoreboard #(int DEPTH = 64);
        logic [VALUE_BITS-1:0] items[$];
        t_result               expected_q[$];
        int                    errors;

        function new();
            errors = 0;
        endfunction

        function int list_size();
            return items.size();
        endfunction

        function logic [VALUE_BITS-1:0] item_at(int k);
            return items[k];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [OPCODE_BITS-1:0] op, logic [POSITION_BITS-1:0] pos,
                                   logic [VALUE_BITS-1:0] val);
            t_result r;
            int      n;
            int      p;
            r = '0;
            n = items.size();
            p = int'(pos);
            case (op)
                OP_INSERT: begin
                    if (p < 1 || p > n + 1) begin
                        r.status = ST_BADPOS;
                    end else if (n >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        items.insert(p - 1, val);
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > n) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.element = items[p - 1];
                        items.delete(p - 1);
                    end
                end
                OP_GET: begin
                    if (p < 1 || p > n) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.element = items[p - 1];
                    end
                end
                OP_LOCATE: begin
                    r.status = ST_NOTFOUND;
                    for (int k = 0; k < n; k++) begin
                        if (items[k] == val) begin
                            r.status = ST_OK;
                            r.found_position = POSITION_BITS'(k + 1);
                            break;
                        end
                    end
                end
                OP_CLEAR: begin
                    items.delete();
                end
                default: begin
                    r.status = ST_BADPOS;
                end
            endcase
            r.list_length = POSITION_BITS'(items.size());
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word with nothing pending: %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.element !== want.element)
                report($sformatf("element %h, want %h", got.element, want.element));
            if (got.found_position !== want.found_position)
                report($sformatf("found_position %0d, want %0d",
                                 got.found_position, want.found_position));
            if (got.list_length !== want.list_length)
                report($sformatf("list_length %0d, want %0d", got.list_length, want.list_length));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // position[6:0], value[38:7], zero pad
    logic [2:0]  s_axis_tuser;   // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // element[31:0], found_position[38:32], list_length[45:39], pad
    logic [1:0]  m_axis_tuser;   // status[1:0]

    list_scoreboard #(LIST_CAPACITY) sb;
    int sent;
    int burst_left;
    bit hold_requested;
    bit hold_done;
    int idle_cycles;

    sequential_list_engine_core #(
        .CAPACITY     (LIST_CAPACITY),
        .ELEMENT_BITS (VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    task automatic push_request(input logic [OPCODE_BITS-1:0] op,
                                input logic [POSITION_BITS-1:0] pos,
                                input logic [VALUE_BITS-1:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, val, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, pos, val);
        sent++;
        if (sent == 400) hold_requested = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 25);
        end
    endtask

    function automatic logic [POSITION_BITS-1:0] pick_position(int limit);
        if (limit >= 1 && $urandom_range(0, 99) < 85)
            return POSITION_BITS'($urandom_range(1, limit));
        return POSITION_BITS'($urandom_range(0, 127));
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int roll;
        int n;
        roll = $urandom_range(0, 9);
        n = sb.list_size();
        if (roll <= 5) return $urandom;
        if (roll == 6) return $urandom_range(0, 3);
        if (roll == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (n > 0) return sb.item_at($urandom_range(0, n - 1));
        return $urandom;
    endfunction

    task automatic pick_request(input int mode, output logic [OPCODE_BITS-1:0] op,
                                output logic [POSITION_BITS-1:0] pos,
                                output logic [VALUE_BITS-1:0] val);
        int n;
        int roll;
        int w_ins, w_del, w_get, w_loc, w_clr;
        n = sb.list_size();
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:   begin w_ins = 80; w_del = 5;  w_get = 7;  w_loc = 7;  w_clr = 0; end
            MODE_DRAIN:  begin w_ins = 10; w_del = 60; w_get = 12; w_loc = 14; w_clr = 2; end
            MODE_MIXED:  begin w_ins = 35; w_del = 25; w_get = 18; w_loc = 17; w_clr = 3; end
            default:     begin w_ins = 10; w_del = 10; w_get = 38; w_loc = 38; w_clr = 2; end
        endcase
        val = pick_value();
        pos = pick_position(n);
        if (roll < w_ins) begin
            op = OP_INSERT;
            pos = pick_position(n + 1);
        end else if (roll < w_ins + w_del) begin
            op = OP_DELETE;
        end else if (roll < w_ins + w_del + w_get) begin
            op = OP_GET;
        end else if (roll < w_ins + w_del + w_get + w_loc) begin
            op = OP_LOCATE;
            if (n > 0 && $urandom_range(0, 3) != 0) val = sb.item_at($urandom_range(0, n - 1));
        end else if (roll < w_ins + w_del + w_get + w_loc + w_clr) begin
            op = OP_CLEAR;
        end else begin
            op = OPCODE_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
            pos = POSITION_BITS'($urandom_range(0, 127));
        end
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            int phase_mode;
            int phase_len;
            phase_mode = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 200);
            if (hold_requested && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            for (int c = 0; c < phase_len; c++) begin
                case (phase_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= (c % 4 == 3);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tuser;
            got.element        = m_axis_tdata[31:0];
            got.found_position = m_axis_tdata[38:32];
            got.list_length    = m_axis_tdata[45:39];
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [OPCODE_BITS-1:0]   op;
        logic [POSITION_BITS-1:0] pos;
        logic [VALUE_BITS-1:0]    val;
        int mode;
        int span;
        sb = new();
        sent = 0;
        burst_left = 8;
        hold_requested = 1'b0;
        hold_done = 1'b0;
        idle_cycles = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_request(OP_GET,    7'd1,   32'h0000_0000);
        push_request(OP_DELETE, 7'd1,   32'h0000_0000);
        push_request(OP_LOCATE, 7'd0,   32'h0000_0000);
        push_request(OP_INSERT, 7'd0,   32'h1111_1111);
        push_request(OP_INSERT, 7'd2,   32'h2222_2222);
        push_request(OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        push_request(OP_INSERT, 7'd1,   32'h8000_0000);
        push_request(OP_INSERT, 7'd3,   32'hFFFF_FFFF);
        push_request(OP_INSERT, 7'd2,   32'h0000_0000);
        push_request(OP_GET,    7'd1,   32'h0000_0000);
        push_request(OP_GET,    7'd4,   32'h0000_0000);
        push_request(OP_GET,    7'd5,   32'h0000_0000);
        push_request(OP_LOCATE, 7'd0,   32'h8000_0000);
        push_request(OP_LOCATE, 7'd127, 32'h1234_5678);
        push_request(OP_DELETE, 7'd2,   32'h0000_0000);
        push_request(OP_DELETE, 7'd3,   32'h0000_0000);
        push_request(OP_DELETE, 7'd0,   32'h0000_0000);
        push_request(OP_FIRST_UNUSED, 7'd1, 32'h0000_0001);
        push_request(OP_MID_UNUSED, 7'd127, 32'h5555_5555);
        push_request(OP_LAST_CODE, 7'd64, 32'hFFFF_FFFF);
        push_request(OP_GET,    7'd127, 32'h0000_0000);
        push_request(OP_INSERT, 7'd127, 32'hAAAA_AAAA);
        push_request(OP_CLEAR,  7'd0,   32'h0000_0000);
        push_request(OP_GET,    7'd1,   32'h0000_0000);
        push_request(OP_CLEAR,  7'd64,  32'hFFFF_FFFF);

        mode = MODE_FILL;
        span = 110;
        while (sent < TOTAL_REQUESTS) begin
            for (int i = 0; i < span && sent < TOTAL_REQUESTS; i++) begin
                pick_request(mode, op, pos, val);
                push_request(op, pos, val);
            end
            mode = $urandom_range(MODE_FILL, MODE_LOOKUP);
            span = $urandom_range(20, 150);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
